### hw/rtl/occ_pkg.sv
// Shared types, constants and the end-around-carry add for the checksum block.
// No dependencies; every other file in hw/rtl imports this package.
package occ_pkg;

  localparam int unsigned SumWidth  = 16;
  localparam int unsigned ByteWidth = 8;

  typedef logic [SumWidth-1:0]  sum_t;
  typedef logic [ByteWidth-1:0] byte_t;

  // One input item as it sits in the input register.
  typedef struct packed {
    logic  valid;
    byte_t data_byte;
    logic  fragment_end;
    logic  packet_end;
  } occ_item_t;

  // One's-complement add with the carry folded back in. The 17-bit sum is at
  // most 0x1fffe, so the fold itself cannot carry again.
  function automatic sum_t ones_add(sum_t acc, sum_t word);
    logic [SumWidth:0] t;
    t = {1'b0, acc} + {1'b0, word};
    return t[SumWidth-1:0] + {{(SumWidth-1){1'b0}}, t[SumWidth]};
  endfunction

endpackage

### hw/rtl/occ_in_stage.sv
// Input register for the checksum block: captures one item per cycle while not stalled.
// Depends on occ_pkg.
module occ_in_stage import occ_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  byte_t     in_data_byte,
  input  logic      in_fragment_end,
  input  logic      in_packet_end,
  input  logic      advance,
  output occ_item_t item
);

  occ_item_t item_r;
  occ_item_t item_nxt;
  logic      take;

  // The register can load when empty or when its item moves on this cycle.
  assign in_stall = item_r.valid && !advance;
  assign take     = in_valid && !in_stall;

  always_comb begin
    item_nxt = item_r;
    if (take) begin
      item_nxt.valid        = 1'b1;
      item_nxt.data_byte    = in_data_byte;
      item_nxt.fragment_end = in_fragment_end;
      item_nxt.packet_end   = in_packet_end;
    end else if (advance) begin
      item_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else begin
      item_r.valid <= item_nxt.valid;
    end
    item_r.data_byte    <= item_nxt.data_byte;
    item_r.fragment_end <= item_nxt.fragment_end;
    item_r.packet_end   <= item_nxt.packet_end;
  end

  assign item = item_r;

endmodule

### hw/rtl/occ_accum.sv
// Running one's-complement sum, byte position and the checksum output register.
// Depends on occ_pkg.
module occ_accum import occ_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  occ_item_t item,
  output logic      advance,
  output logic      out_valid,
  input  logic      out_stall,
  output sum_t      out_checksum
);

  sum_t sum_r, sum_nxt;
  logic odd_r, odd_nxt;
  logic out_valid_r, out_valid_nxt;
  sum_t checksum_r, checksum_nxt;
  sum_t word;
  sum_t added;
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;
  // Only a packet-ending item needs room in the output register.
  assign advance  = item.valid && (!item.packet_end || out_free);

  // High byte goes in shifted up, low byte as is.
  assign word  = odd_r ? {{(SumWidth-ByteWidth){1'b0}}, item.data_byte}
                       : {item.data_byte, {(SumWidth-ByteWidth){1'b0}}};
  assign added = ones_add(sum_r, word);

  always_comb begin
    sum_nxt       = sum_r;
    odd_nxt       = odd_r;
    checksum_nxt  = checksum_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (advance) begin
      if (item.packet_end) begin
        sum_nxt       = '0;
        odd_nxt       = 1'b0;
        checksum_nxt  = ~added;
        out_valid_nxt = 1'b1;
      end else begin
        sum_nxt = added;
        odd_nxt = item.fragment_end ? 1'b0 : !odd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      odd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      odd_r       <= odd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    checksum_r <= checksum_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_checksum = checksum_r;

endmodule

### hw/rtl/ones_complement_checksum.sv
// Internet-style checksum over a fragmented byte stream, one byte per item.
// The checksum is loaded into the output register when the packet's last byte leaves the input register.
// Throughput: one byte per cycle; the 17-bit add and fold sit between the input
// register and the sum/output registers. A stalled checksum holds up only the last byte.
// Reset (rst_n low, synchronous) empties both registers and clears sum and byte position.
// Depends on occ_pkg, occ_in_stage and occ_accum.
module ones_complement_checksum import occ_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  byte_t in_data_byte,
  input  logic  in_fragment_end,
  input  logic  in_packet_end,
  output logic  out_valid,
  input  logic  out_stall,
  output sum_t  out_checksum
);

  occ_item_t item;
  logic      advance;

  occ_in_stage u_in_stage (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_fragment_end (in_fragment_end),
    .in_packet_end   (in_packet_end),
    .advance         (advance),
    .item            (item)
  );

  occ_accum u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .item         (item),
    .advance      (advance),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_checksum (out_checksum)
  );

endmodule
